// ===== rtl/q4dp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q4dp_pkg: shared types and constants of the 4-bit block dot product
// Widths of the request fields, the queue entry and the accumulators.
// ============================================================================
package q4dp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ACT_W     = 16;
    localparam int unsigned SCALE_W   = 16;
    localparam int unsigned WEIGHT_W  = 4;
    localparam int unsigned PROD_W    = WEIGHT_W + ACT_W;
    localparam int unsigned PAIR_W    = PROD_W + 1;
    localparam int unsigned BSUM_W    = 25;
    localparam int unsigned BPROD_W   = BSUM_W + SCALE_W;
    localparam int unsigned TOTAL_W   = 56;

    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [PAIR_W-1:0]  pair_sum;
        logic signed [SCALE_W-1:0] scale;
        logic                      closes_block;
        logic                      closes_row;
    } t_item;

endpackage

// ===== rtl/q4dp_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q4dp_front: request decode and pair multiply
// Splits the packed byte into two offset weights, forms both products and
// their sum, and classifies the request as block or row closing.
// ============================================================================
module q4dp_front (
    input  logic [q4dp_pkg::BYTE_W-1:0]         i_packed_byte,
    input  logic signed [q4dp_pkg::ACT_W-1:0]   i_act_even,
    input  logic signed [q4dp_pkg::ACT_W-1:0]   i_act_odd,
    input  logic signed [q4dp_pkg::SCALE_W-1:0] i_block_scale,
    input  logic                                i_block_last,
    input  logic                                i_row_last,
    output q4dp_pkg::t_item                     o_item
);
    import q4dp_pkg::*;

    logic signed [WEIGHT_W-1:0] w_even;
    logic signed [WEIGHT_W-1:0] w_odd;
    logic signed [PROD_W-1:0]   p_even;
    logic signed [PROD_W-1:0]   p_odd;

    // A nibble minus eight is the nibble with its top bit inverted.
    assign w_even = signed'({~i_packed_byte[3], i_packed_byte[2:0]});
    assign w_odd  = signed'({~i_packed_byte[7], i_packed_byte[6:4]});

    assign p_even = PROD_W'(w_even) * PROD_W'(i_act_even);
    assign p_odd  = PROD_W'(w_odd) * PROD_W'(i_act_odd);

    always_comb begin
        o_item.pair_sum     = PAIR_W'(p_even) + PAIR_W'(p_odd);
        o_item.scale        = i_block_scale;
        o_item.closes_block = i_block_last | i_row_last;
        o_item.closes_row   = i_row_last;
    end

endmodule

// ===== rtl/q4dp_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q4dp_queue: short queue between front and back
// Holds decoded requests so that the front and the back stall independently.
// ============================================================================
module q4dp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  q4dp_pkg::t_item i_wr_item,
    output logic            o_full,
    input  logic            i_rd,
    output q4dp_pkg::t_item o_rd_item,
    output logic            o_empty
);
    import q4dp_pkg::*;

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 wr_fire;
    logic                 rd_fire;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_fire   = i_wr & ~o_full;
    assign rd_fire   = i_rd & ~o_empty;
    assign o_rd_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count exceeds depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_fire && !rd_fire) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count missed a write");

endmodule

// ===== rtl/q4dp_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q4dp_back: block and row accumulation
// Accumulates pair sums into the block sum, scales closed blocks, adds them
// to the saturating row total and holds the row result for the receiver.
// ============================================================================
module q4dp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  q4dp_pkg::t_item                      i_item,
    input  logic                                 i_item_valid,
    output logic                                 o_item_take,
    output logic signed [q4dp_pkg::TOTAL_W-1:0]  o_dot_value,
    output logic                                 o_saturated,
    output logic                                 o_out_valid,
    input  logic                                 i_out_take
);
    import q4dp_pkg::*;

    logic                       en;
    logic                       a_fire;
    logic signed [BSUM_W:0]     a_raw;
    logic                       a_ovf;
    logic signed [BSUM_W-1:0]   a_sum;

    logic signed [BSUM_W-1:0]   r_bsum;
    logic                       r_bclip;

    logic                       r_b_valid;
    logic                       r_b_row;
    logic                       r_b_clip;
    logic signed [BSUM_W-1:0]   r_b_sum;
    logic signed [SCALE_W-1:0]  r_b_scale;

    logic                       r_c_valid;
    logic                       r_c_row;
    logic                       r_c_clip;
    logic signed [BPROD_W-1:0]  r_c_prod;

    logic signed [TOTAL_W:0]    c_raw;
    logic                       c_ovf;
    logic signed [TOTAL_W-1:0]  c_total;

    logic signed [TOTAL_W-1:0]  r_total;
    logic                       r_clip_seen;

    logic                       r_out_valid;
    logic signed [TOTAL_W-1:0]  r_out_value;
    logic                       r_out_sat;

    assign en          = ~r_out_valid | i_out_take;
    assign a_fire      = en & i_item_valid;
    assign o_item_take = a_fire;

    always_comb begin
        a_raw = (BSUM_W+1)'(r_bsum) + (BSUM_W+1)'(i_item.pair_sum);
        a_ovf = (a_raw[BSUM_W] != a_raw[BSUM_W-1]);
        if (!a_ovf) begin
            a_sum = a_raw[BSUM_W-1:0];
        end else if (a_raw[BSUM_W]) begin
            a_sum = {1'b1, {(BSUM_W-1){1'b0}}};
        end else begin
            a_sum = {1'b0, {(BSUM_W-1){1'b1}}};
        end

        c_raw = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(r_c_prod);
        c_ovf = (c_raw[TOTAL_W] != c_raw[TOTAL_W-1]);
        if (!c_ovf) begin
            c_total = c_raw[TOTAL_W-1:0];
        end else if (c_raw[TOTAL_W]) begin
            c_total = {1'b1, {(TOTAL_W-1){1'b0}}};
        end else begin
            c_total = {1'b0, {(TOTAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sum   <= a_sum;
            r_b_scale <= i_item.scale;
            r_b_row   <= i_item.closes_row;
            r_b_clip  <= r_bclip | a_ovf;
            r_c_prod  <= BPROD_W'(r_b_sum) * BPROD_W'(r_b_scale);
            r_c_row   <= r_b_row;
            r_c_clip  <= r_b_clip;
        end
        if (en && r_c_valid && r_c_row) begin
            r_out_value <= c_total;
            r_out_sat   <= r_clip_seen | r_c_clip | c_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsum      <= '0;
            r_bclip     <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_total     <= '0;
            r_clip_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_fire) begin
                if (i_item.closes_block) begin
                    r_bsum  <= '0;
                    r_bclip <= 1'b0;
                end else begin
                    r_bsum  <= a_sum;
                    r_bclip <= r_bclip | a_ovf;
                end
            end
            if (en) begin
                r_b_valid <= a_fire & i_item.closes_block;
                r_c_valid <= r_b_valid;
                if (r_c_valid) begin
                    if (r_c_row) begin
                        r_total     <= '0;
                        r_clip_seen <= 1'b0;
                    end else begin
                        r_total     <= c_total;
                        r_clip_seen <= r_clip_seen | r_c_clip | c_ovf;
                    end
                end
            end
            if (en && r_c_valid && r_c_row) begin
                r_out_valid <= 1'b1;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_dot_value = r_out_value;
    assign o_saturated = r_out_sat;
    assign o_out_valid = r_out_valid;

    a_take_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_take |-> (!r_out_valid || i_out_take))
        else $error("request taken while the result register is blocked");

    a_row_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_valid && r_c_row) |=> (r_out_valid && r_total == '0 && !r_clip_seen))
        else $error("row close did not load the result and clear the total");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_take) |=> (r_out_valid && $stable(r_out_value)))
        else $error("waiting result was lost or changed");

endmodule

// ===== rtl/q4_block_dot_product.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q4_block_dot_product: row dot product of packed 4-bit weights
// Accumulates offset 4-bit weights times Q4.12 activations into scaled
// block sums and emits one saturating row total per row.
// ============================================================================
// Usage: the input side is a queue write port. A request (one packed weight
// byte, its two activations, the block scale and the block and row closing
// flags) is taken at a clock edge where push is high and full is low. The
// result side is a queue read port: while empty is low, o_dot_value (scaled
// by 2^26) and o_saturated show the row result, and it is taken at an edge
// where pop is high.
// A request is decoded and multiplied as it enters a four-entry queue. The
// back end runs three register stages: block sum, block scale multiply, and
// row total. A row result passes through these stages in turn after its
// closing request is taken. Unless a waiting result blocks it, the back end
// takes one request per cycle, set by the block sum adder loop.
// When a result waits and pop is low, the back end holds; the queue absorbs
// up to four requests before full rises. Reset clears the block sum, the row
// total and empties the queue and the result register.
// ============================================================================
module q4_block_dot_product (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [q4dp_pkg::BYTE_W-1:0]          i_packed_byte,
    input  logic signed [q4dp_pkg::ACT_W-1:0]    i_act_even,
    input  logic signed [q4dp_pkg::ACT_W-1:0]    i_act_odd,
    input  logic signed [q4dp_pkg::SCALE_W-1:0]  i_block_scale,
    input  logic                                 i_block_last,
    input  logic                                 i_row_last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [q4dp_pkg::TOTAL_W-1:0]  o_dot_value,
    output logic                                 o_saturated
);
    import q4dp_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  queue_empty;
    logic  queue_take;
    logic  out_valid;

    q4dp_front u_front (
        .i_packed_byte (i_packed_byte),
        .i_act_even    (i_act_even),
        .i_act_odd     (i_act_odd),
        .i_block_scale (i_block_scale),
        .i_block_last  (i_block_last),
        .i_row_last    (i_row_last),
        .o_item        (front_item)
    );

    q4dp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_item (front_item),
        .o_full    (full),
        .i_rd      (queue_take),
        .o_rd_item (queue_item),
        .o_empty   (queue_empty)
    );

    q4dp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_item_valid (~queue_empty),
        .o_item_take  (queue_take),
        .o_dot_value  (o_dot_value),
        .o_saturated  (o_saturated),
        .o_out_valid  (out_valid),
        .i_out_take   (pop)
    );

    assign empty = ~out_valid;

endmodule
